// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the waveshaper RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CW_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define CW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CW_ASSERT(lbl, clk, rstn, prop, msg)
`define CW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/cwdc_pkg.sv
// ---------------------------------------------------------------------------
// cwdc_pkg
// Types and constants shared by the waveshaper front end and back end.
// ---------------------------------------------------------------------------
`default_nettype none
package cwdc_pkg;
	localparam int TBL_DEPTH  = 4096;
	localparam int TBL_AW     = $clog2(TBL_DEPTH);
	localparam int COEF_DEPTH = 256;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);
	localparam int Q16_SHIFT  = 16;
	localparam int Q30_SHIFT  = 30;

	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_COEF   = 2'd1;
	localparam logic [1:0] ACT_BUILD  = 2'd2;
	localparam logic [1:0] ACT_RSVD   = 2'd3;

	localparam logic [1:0] CFG_COEF_COUNT = 2'd0;
	localparam logic [1:0] CFG_NORMALIZE  = 2'd1;
	localparam logic [1:0] CFG_DC_ON      = 2'd2;
	localparam logic [1:0] CFG_DC_COEFF   = 2'd3;

	typedef struct packed {
		logic signed [23:0] coef_value;
		logic [7:0]         coef_index;
		logic signed [23:0] sample_in;
		logic [1:0]         action;
	} item_t;

	typedef struct packed {
		logic [8:0]  coef_count;
		logic        normalize;
		logic        dc_filter_on;
		logic [15:0] dc_coeff;
	} cfg_t;
endpackage
`default_nettype wire

// File: sv/cwdc_front.sv
// ---------------------------------------------------------------------------
// cwdc_front
// Input acceptance: two-entry queue holding transactions for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module cwdc_front import cwdc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // action, sample_in, coef_index, coef_value, pad
	output item_t            item,
	output logic             item_valid,
	input  wire logic        item_pop
);
	item_t      buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign s_tready   = (count_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign item_valid = (count_q != 2'd0);
	assign item       = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= item_t'(s_tdata[57:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (item_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, item_pop};
		end
	end
endmodule
`default_nettype wire

// File: sv/cwdc_back.sv
// ---------------------------------------------------------------------------
// cwdc_back
// Execution: coefficient store, shape table build/normalise, sample lookup,
// DC blocker and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cwdc_back import cwdc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire item_t       item,
	input  wire logic        item_valid,
	output logic             item_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata
);
	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_SRD  = 12'b000000000010,
		ST_SOUT = 12'b000000000100,
		ST_BROW = 12'b000000001000,
		ST_BRD  = 12'b000000010000,
		ST_BMUL = 12'b000000100000,
		ST_BACC = 12'b000001000000,
		ST_BWR  = 12'b000010000000,
		ST_NRD  = 12'b000100000000,
		ST_NLD  = 12'b001000000000,
		ST_NDIV = 12'b010000000000,
		ST_NWR  = 12'b100000000000
	} state_t;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1 <<< Q30_SHIFT;
	localparam logic signed [23:0] ONE_Q16 = 24'sd1 <<< Q16_SHIFT;

	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		logic signed [39:0] hi, lo;
		hi = 40'sd8388607;
		lo = -40'sd8388608;
		if (v > hi) return 24'sh7FFFFF;
		else if (v < lo) return 24'sh800000;
		else return v[23:0];
	endfunction

	state_t state_q;

	logic signed [23:0] coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0] cvalid_q;
	logic signed [23:0] coef_rd_q;
	logic               cok_q, kone_q;
	logic signed [23:0] coef0_q;

	logic signed [23:0] tbl_mem [TBL_DEPTH];
	logic signed [23:0] tbl_rd_q;
	logic [TBL_AW-1:0]  tbl_raddr;
	logic               tbl_we;
	logic signed [23:0] tbl_wdata;

	logic [TBL_AW:0]    j_q;
	logic [8:0]         k_q;
	logic [8:0]         n_use;
	logic signed [39:0] acc_q;
	logic signed [31:0] ta_q, tb_q, p_q;
	logic signed [55:0] pc_s1;
	logic signed [63:0] pp_s1;
	logic               cpos_s1;
	logic signed [23:0] mn_q, mx_q;

	logic [44:0]        rem_q, dsh_q;
	logic [17:0]        quo_q;
	logic [4:0]         bit_q;
	logic               flat_q;

	logic signed [23:0] xn_q;
	logic signed [48:0] fb_s1;
	logic signed [23:0] prev_in_q;
	logic signed [31:0] prev_out_q;
	logic               out_valid_q;
	logic [23:0]        out_data_q;

	logic [23:0]            u_s;
	logic [24+TBL_AW-1:0]   sidx_prod;
	logic signed [23:0]     cval;
	logic signed [25:0]     rc;
	logic signed [39:0]     acc_n;
	logic signed [34:0]     rp;
	logic signed [35:0]     nx_raw;
	logic signed [31:0]     nx;
	logic signed [31:0]     p_row;
	logic signed [24:0]     den;
	logic signed [24:0]     diff;
	logic signed [23:0]     row_val;
	logic                   ge;
	logic signed [32:0]     fbr;
	logic signed [34:0]     ysum;
	logic signed [31:0]     yn;
	logic                   out_free;
	logic                   last_row;

	assign item_pop = (state_q == ST_IDLE) && item_valid;
	assign n_use    = (cfg.coef_count > 9'(COEF_DEPTH)) ? 9'(COEF_DEPTH) : cfg.coef_count;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign out_free = !out_valid_q || m_tready;
	assign last_row = (j_q == (TBL_AW+1)'(TBL_DEPTH-1));

	always_comb begin
		u_s       = {~item.sample_in[23], item.sample_in[22:0]};
		sidx_prod = (24+TBL_AW)'(u_s) * (24+TBL_AW)'(TBL_DEPTH-1);
		tbl_raddr = (state_q == ST_IDLE) ? sidx_prod[24+TBL_AW-1:24] : j_q[TBL_AW-1:0];
		p_row     = $signed({{(32-TBL_AW-(31-TBL_AW)){1'b0}}, j_q[TBL_AW-1:0],
			{(31-TBL_AW){1'b0}}}) - ONE_Q30;
		cval      = cok_q ? coef_rd_q : (kone_q ? ONE_Q16 : 24'sd0);
		rc        = 26'((pc_s1 + (56'sd1 <<< (Q30_SHIFT-1))) >>> Q30_SHIFT);
		acc_n     = acc_q + (cpos_s1 ? 40'(rc) : 40'sd0);
		rp        = 35'((pp_s1 + (64'sd1 <<< (Q30_SHIFT-2))) >>> (Q30_SHIFT-1));
		nx_raw    = 36'(rp) - 36'(ta_q);
		if (nx_raw > 36'(ONE_Q30)) nx = ONE_Q30;
		else if (nx_raw < -36'(ONE_Q30)) nx = -ONE_Q30;
		else nx = nx_raw[31:0];
		row_val   = sat24(acc_q);
		den       = 25'(mx_q) - 25'(mn_q);
		diff      = 25'(tbl_rd_q) - 25'(mn_q);
		ge        = (rem_q >= dsh_q);
		if (flat_q) tbl_wdata = (coef0_q != 24'sd0) ? ONE_Q16 : 24'sd0;
		else tbl_wdata = 24'($signed({1'b0, quo_q})) - ONE_Q16;
		tbl_we    = (state_q == ST_BWR) || (state_q == ST_NWR);
		if (state_q == ST_BWR) tbl_wdata = row_val;
		fbr       = 33'((fb_s1 + 49'sd32768) >>> Q16_SHIFT);
		ysum      = 35'(xn_q) - 35'(prev_in_q) + 35'(fbr);
		if (ysum > 35'sd2147483647) yn = 32'sh7FFFFFFF;
		else if (ysum < -35'sd2147483648) yn = 32'sh80000000;
		else yn = ysum[31:0];
		if (!cfg.dc_filter_on) yn = 32'(xn_q);
	end

	always_ff @(posedge clk) begin
		if (item_pop && item.action == ACT_COEF) begin
			coef_mem[item.coef_index] <= item.coef_value;
		end
		coef_rd_q <= coef_mem[k_q[COEF_AW-1:0]];
		cok_q     <= cvalid_q[k_q[COEF_AW-1:0]];
		kone_q    <= (k_q == 9'd1);
		if (tbl_we) begin
			tbl_mem[j_q[TBL_AW-1:0]] <= tbl_wdata;
		end
		tbl_rd_q <= tbl_mem[tbl_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_BROW: begin
				acc_q <= 40'sd0;
				ta_q  <= ONE_Q30;
				tb_q  <= p_row;
				p_q   <= p_row;
			end
			ST_BMUL: begin
				pc_s1   <= cval * 56'(ta_q);
				pp_s1   <= 64'(p_q) * 64'(tb_q);
				cpos_s1 <= (cval > 24'sd0);
			end
			ST_BACC: begin
				acc_q <= acc_n;
				ta_q  <= tb_q;
				tb_q  <= nx;
			end
			ST_NLD: begin
				rem_q  <= {2'b0, diff[24:0], 18'b0} + 45'(den);
				dsh_q  <= {1'b0, den[24:0], 1'b0, 18'b0} >> 1;
				quo_q  <= 18'd0;
				flat_q <= (den == 25'sd0);
			end
			ST_NDIV: begin
				if (ge) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[16:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			ST_SRD: begin
				xn_q  <= tbl_rd_q;
				fb_s1 <= $signed({1'b0, cfg.dc_coeff}) * 49'(prev_out_q);
			end
			ST_SOUT: begin
				if (out_free) out_data_q <= sat24(40'(yn));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cvalid_q    <= '0;
			coef0_q     <= 24'sd0;
			j_q         <= '0;
			k_q         <= '0;
			bit_q       <= '0;
			mn_q        <= 24'sd0;
			mx_q        <= 24'sd0;
			prev_in_q   <= 24'sd0;
			prev_out_q  <= 32'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SOUT && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.action)
							ACT_SAMPLE: state_q <= ST_SRD;
							ACT_COEF: begin
								cvalid_q[item.coef_index] <= 1'b1;
								if (item.coef_index == 8'd0) coef0_q <= item.coef_value;
							end
							ACT_BUILD: begin
								j_q     <= '0;
								mn_q    <= ONE_Q16;
								mx_q    <= -ONE_Q16;
								state_q <= ST_BROW;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SRD: state_q <= ST_SOUT;
				ST_SOUT: begin
					if (out_free) begin
						prev_in_q   <= xn_q;
						prev_out_q  <= yn;
						state_q     <= ST_IDLE;
					end
				end
				ST_BROW: begin
					k_q     <= '0;
					state_q <= (n_use == 9'd0) ? ST_BWR : ST_BRD;
				end
				ST_BRD: state_q <= ST_BMUL;
				ST_BMUL: state_q <= ST_BACC;
				ST_BACC: begin
					k_q     <= k_q + 9'd1;
					state_q <= (k_q + 9'd1 == n_use) ? ST_BWR : ST_BRD;
				end
				ST_BWR: begin
					if (row_val < mn_q) mn_q <= row_val;
					if (row_val > mx_q) mx_q <= row_val;
					if (last_row) begin
						j_q     <= '0;
						state_q <= cfg.normalize ? ST_NRD : ST_IDLE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_BROW;
					end
				end
				ST_NRD: state_q <= ST_NLD;
				ST_NLD: begin
					bit_q   <= '0;
					state_q <= (den == 25'sd0) ? ST_NWR : ST_NDIV;
				end
				ST_NDIV: begin
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'd17) state_q <= ST_NWR;
				end
				ST_NWR: begin
					if (last_row) begin
						state_q <= ST_IDLE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_NRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CW_ASSERT(a_pop_idle, clk, arst_n, item_pop |-> state_q == ST_IDLE, "pop outside idle")
	`CW_ASSERT(a_rose_out, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_SOUT), "stray result")
	`CW_ASSERT(a_div_len, clk, arst_n, (state_q == ST_NDIV && bit_q == 5'd17) |=> state_q == ST_NWR, "divider overrun")
endmodule
`default_nettype wire

// File: sv/chebyshev_waveshaper_dc_block.sv
// ---------------------------------------------------------------------------
// chebyshev_waveshaper_dc_block
// Chebyshev polynomial waveshaper with table build and DC blocker.
// ---------------------------------------------------------------------------
// Use: transactions enter on s_tvalid/s_tready/s_tdata. Action 0 is a sample
// and yields one result on m_tvalid/m_tready/m_tdata (Q8.16, saturating).
// Action 1 writes a coefficient, action 2 rebuilds the shape table; neither
// yields a result. Registers are written via cfg_we/cfg_addr/cfg_wdata; the
// user must write them only while the block is idle, which it does not
// enforce. The back end runs one transaction at a time and pops no new item
// until the last is done. Rebuild: per table entry ST_BROW, then ST_BRD,
// ST_BMUL and ST_BACC per coefficient in use (one shared multiply pair per
// term) and ST_BWR, over 4096 entries; with normalisation, then per entry
// ST_NRD, ST_NLD, the bit-serial divider ST_NDIV (skipped for a flat table)
// and ST_NWR. A two-entry input queue keeps accepting while a result waits
// until both entries are full; a stalled receiver holds the result register
// and holds the back end in ST_SOUT at its next result. Reset clears control,
// the filter history and the coefficient store to its default (coefficient
// 1 = 1.0); the table holds nothing until rebuilt.
// ---------------------------------------------------------------------------
`default_nettype none
module chebyshev_waveshaper_dc_block import cwdc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // action, sample_in, coef_index, coef_value, pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // sample_out
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata
);
	cfg_t  cfg_q;
	item_t item;
	logic  item_valid, item_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_count   <= 9'd2;
			cfg_q.normalize    <= 1'b1;
			cfg_q.dc_filter_on <= 1'b1;
			cfg_q.dc_coeff     <= 16'd65493;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_COEF_COUNT: cfg_q.coef_count   <= cfg_wdata[8:0];
				CFG_NORMALIZE:  cfg_q.normalize    <= cfg_wdata[0];
				CFG_DC_ON:      cfg_q.dc_filter_on <= cfg_wdata[0];
				CFG_DC_COEFF:   cfg_q.dc_coeff     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	cwdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	cwdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);
endmodule
`default_nettype wire
